// ----- rtl/mmt_pkg.sv -----
package mmt_pkg;

  localparam int OP_W    = 2;
  localparam int IDX4_W  = 4;
  localparam int VALUE_W = 16;
  localparam int SUM_W   = 36;
  localparam int STAT_W  = 2;
  localparam int DIM_W   = 5;
  localparam int CFG_IDX_W = 3;
  localparam int PROD_W  = 2 * VALUE_W;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [OP_W-1:0] OP_WRITE_A = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE_B = 2'd1;
  localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_MISMATCH = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_A_ROWS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_A_COLS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_B_ROWS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_B_COLS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TRANS_A = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TRANS_B = 3'd5;

  localparam logic [DIM_W-1:0] DIM_RESET = 5'd16;

  typedef enum logic [1:0] {
    JOB_WR_A,
    JOB_WR_B,
    JOB_MAC,
    JOB_ERR
  } job_kind_t;

  typedef struct packed {
    job_kind_t                 kind;
    logic [IDX4_W-1:0]         row;
    logic [IDX4_W-1:0]         col;
    logic signed [VALUE_W-1:0] value;
    logic [STAT_W-1:0]         status;
  } job_t;

  typedef struct packed {
    logic             trans_a;
    logic             trans_b;
    logic [DIM_W-1:0] inner;
  } geom_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RUN,
    BK_DRAIN,
    BK_DONE
  } back_state_t;

endpackage

// ----- rtl/mmt_in_if.sv -----
interface mmt_in_if;
  logic                               valid;
  logic                               ready;
  logic [mmt_pkg::OP_W-1:0]           op;
  logic [mmt_pkg::IDX4_W-1:0]         row;
  logic [mmt_pkg::IDX4_W-1:0]         col;
  logic signed [mmt_pkg::VALUE_W-1:0] value;

  modport source (output valid, op, row, col, value, input ready);
  modport sink (input valid, op, row, col, value, output ready);
endinterface

// ----- rtl/mmt_out_if.sv -----
interface mmt_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [mmt_pkg::SUM_W-1:0] sum;
  logic [mmt_pkg::STAT_W-1:0]       status;

  modport source (output valid, sum, status, input ready);
  modport sink (input valid, sum, status, output ready);
endinterface

// ----- rtl/mmt_front.sv -----
module mmt_front #(
  parameter int MAX_DIM = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_en,
  input  logic [mmt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mmt_pkg::DIM_W-1:0]       cfg_data,
  mmt_in_if.sink                          items,
  input  logic                            full,
  output logic                            push,
  output mmt_pkg::job_t                   push_job,
  output mmt_pkg::geom_t                  geom
);

  localparam int EFF_MAX = (MAX_DIM > 31) ? 31 : MAX_DIM;
  localparam logic [mmt_pkg::DIM_W-1:0] DIM_CAP = mmt_pkg::DIM_W'(EFF_MAX);

  logic [mmt_pkg::DIM_W-1:0] a_rows, a_cols, b_rows, b_cols;
  logic                      trans_a, trans_b;

  logic [mmt_pkg::DIM_W-1:0] ar, ac, br, bc;
  logic [mmt_pkg::DIM_W-1:0] inner_a, inner_b, res_rows, res_cols;
  logic [mmt_pkg::DIM_W-1:0] row_x, col_x;
  logic                      keep;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_rows  <= mmt_pkg::DIM_RESET;
      a_cols  <= mmt_pkg::DIM_RESET;
      b_rows  <= mmt_pkg::DIM_RESET;
      b_cols  <= mmt_pkg::DIM_RESET;
      trans_a <= 1'b0;
      trans_b <= 1'b0;
    end else if (cfg_en) begin
      case (cfg_index)
        mmt_pkg::CFG_A_ROWS:  a_rows  <= cfg_data;
        mmt_pkg::CFG_A_COLS:  a_cols  <= cfg_data;
        mmt_pkg::CFG_B_ROWS:  b_rows  <= cfg_data;
        mmt_pkg::CFG_B_COLS:  b_cols  <= cfg_data;
        mmt_pkg::CFG_TRANS_A: trans_a <= cfg_data[0];
        mmt_pkg::CFG_TRANS_B: trans_b <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Clamp each dimension to the store size, and to at most 31.
  assign ar = (a_rows > DIM_CAP) ? DIM_CAP : a_rows;
  assign ac = (a_cols > DIM_CAP) ? DIM_CAP : a_cols;
  assign br = (b_rows > DIM_CAP) ? DIM_CAP : b_rows;
  assign bc = (b_cols > DIM_CAP) ? DIM_CAP : b_cols;

  assign inner_a  = trans_a ? ar : ac;
  assign inner_b  = trans_b ? bc : br;
  assign res_rows = trans_a ? ac : ar;
  assign res_cols = trans_b ? br : bc;

  assign row_x = {1'b0, items.row};
  assign col_x = {1'b0, items.col};

  always_comb begin
    keep            = 1'b0;
    push_job.kind   = mmt_pkg::JOB_MAC;
    push_job.row    = items.row;
    push_job.col    = items.col;
    push_job.value  = items.value;
    push_job.status = mmt_pkg::ST_OK;
    case (items.op)
      mmt_pkg::OP_WRITE_A: begin
        keep          = (row_x < ar) && (col_x < ac);
        push_job.kind = mmt_pkg::JOB_WR_A;
      end
      mmt_pkg::OP_WRITE_B: begin
        keep          = (row_x < br) && (col_x < bc);
        push_job.kind = mmt_pkg::JOB_WR_B;
      end
      mmt_pkg::OP_COMPUTE: begin
        keep = 1'b1;
        // Mismatch takes precedence over the index check.
        if (inner_a != inner_b) begin
          push_job.kind   = mmt_pkg::JOB_ERR;
          push_job.status = mmt_pkg::ST_MISMATCH;
        end else if ((row_x >= res_rows) || (col_x >= res_cols)) begin
          push_job.kind   = mmt_pkg::JOB_ERR;
          push_job.status = mmt_pkg::ST_RANGE;
        end
      end
      default: keep = 1'b0;
    endcase
  end

  assign items.ready = !full;
  assign push        = items.valid && !full && keep;

  assign geom.trans_a = trans_a;
  assign geom.trans_b = trans_b;
  assign geom.inner   = inner_a;

endmodule

// ----- rtl/mmt_fifo.sv -----
module mmt_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  mmt_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output mmt_pkg::job_t head,
  output logic          empty
);

  localparam int DEPTH = mmt_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  mmt_pkg::job_t   slots [DEPTH];
  logic [PW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   count;

  assign full  = (count == FULL_COUNT);
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

endmodule

// ----- rtl/mmt_back.sv -----
module mmt_back #(
  parameter int MAX_DIM = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           empty,
  input  mmt_pkg::job_t  head,
  output logic           pop,
  input  mmt_pkg::geom_t geom,
  mmt_out_if.source      results
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int IDX_W = $clog2(MAX_DIM);
  localparam int CW    = $clog2(MAX_DIM + 1);

  logic [mmt_pkg::VALUE_W-1:0] a_mem [DEPTH];
  logic [mmt_pkg::VALUE_W-1:0] b_mem [DEPTH];

  mmt_pkg::back_state_t state, state_next;

  logic [CW-1:0]                     k, n;
  logic [mmt_pkg::IDX4_W-1:0]        job_row, job_col;
  logic [mmt_pkg::STAT_W-1:0]        job_status;
  logic signed [mmt_pkg::VALUE_W-1:0] a_q, b_q;
  logic signed [mmt_pkg::PROD_W-1:0]  prod;
  logic signed [mmt_pkg::SUM_W-1:0]   acc;
  logic                              rd_valid, prod_valid;

  logic                              out_valid;
  logic signed [mmt_pkg::SUM_W-1:0]   out_sum;
  logic [mmt_pkg::STAT_W-1:0]        out_status;

  logic                              wr_a, wr_b, issue, load_out;
  logic [AW-1:0]                     wr_addr, a_addr, b_addr;
  logic [IDX_W-1:0]                  kk;

  assign n  = CW'(geom.inner);
  assign kk = k[IDX_W-1:0];

  assign wr_addr = AW'(int'(head.row) * MAX_DIM + int'(head.col));
  assign a_addr  = geom.trans_a ? AW'(int'(kk) * MAX_DIM + int'(job_row))
                                : AW'(int'(job_row) * MAX_DIM + int'(kk));
  assign b_addr  = geom.trans_b ? AW'(int'(job_col) * MAX_DIM + int'(kk))
                                : AW'(int'(kk) * MAX_DIM + int'(job_col));

  always_comb begin
    pop      = 1'b0;
    issue    = 1'b0;
    load_out = 1'b0;
    case (state)
      mmt_pkg::BK_IDLE: pop      = !empty;
      mmt_pkg::BK_RUN:  issue    = (k != n);
      mmt_pkg::BK_DONE: load_out = !out_valid || results.ready;
      default: ;
    endcase
    wr_a = pop && (head.kind == mmt_pkg::JOB_WR_A);
    wr_b = pop && (head.kind == mmt_pkg::JOB_WR_B);
  end

  always_comb begin
    state_next = state;
    case (state)
      mmt_pkg::BK_IDLE: begin
        if (!empty) begin
          case (head.kind)
            mmt_pkg::JOB_MAC: state_next = mmt_pkg::BK_RUN;
            mmt_pkg::JOB_ERR: state_next = mmt_pkg::BK_DONE;
            default:          state_next = mmt_pkg::BK_IDLE;
          endcase
        end
      end
      mmt_pkg::BK_RUN: begin
        if (k == n) state_next = mmt_pkg::BK_DRAIN;
      end
      mmt_pkg::BK_DRAIN: begin
        if (!rd_valid && !prod_valid) state_next = mmt_pkg::BK_DONE;
      end
      mmt_pkg::BK_DONE: begin
        if (load_out) state_next = mmt_pkg::BK_IDLE;
      end
      default: state_next = mmt_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= mmt_pkg::BK_IDLE;
      rd_valid   <= 1'b0;
      prod_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      rd_valid   <= issue;
      prod_valid <= rd_valid;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job_row    <= head.row;
      job_col    <= head.col;
      job_status <= head.status;
      acc        <= '0;
      k          <= '0;
    end else if (prod_valid) begin
      acc <= acc + mmt_pkg::SUM_W'(prod);
    end
    if (issue) begin
      k   <= k + 1'b1;
      a_q <= a_mem[a_addr];
      b_q <= b_mem[b_addr];
    end
    if (rd_valid) begin
      prod <= a_q * b_q;
    end
    if (wr_a) begin
      a_mem[wr_addr] <= head.value;
    end
    if (wr_b) begin
      b_mem[wr_addr] <= head.value;
    end
    if (load_out) begin
      out_sum    <= acc;
      out_status <= job_status;
    end
  end

  assign results.valid  = out_valid;
  assign results.sum    = out_sum;
  assign results.status = out_status;

endmodule

// ----- rtl/matrix_multiply_transpose_core.sv -----
// Matrix multiply with optional transposition of A and B, one result element per compute
// transaction. Write transactions (op 0 and 1) store one signed Q8.8 element of A or B at a
// stored row and column; writes outside the configured dimensions are dropped and give no
// result, as does op 3. A compute transaction (op 2) returns the exact signed Q20.16 dot
// product over the inner dimension n, or status 1 (inner dimensions differ) or status 2
// (result index out of range) with a zero sum. The front classifies each transaction in the
// cycle it is taken and forwards it through a four-entry queue; the back performs it in
// order. Throughput is set by the single multiply-accumulate unit reading one element of each
// store per cycle: a write is stored as it leaves the queue; a valid compute issues its n reads,
// drains the read and product registers, then waits in the done state until the output register
// can take the result; an error goes straight from idle to the done state. The result sits in
// an output register, so the front keeps taking transactions while a result waits, until the
// queue fills. The stores are not cleared by reset; read only elements written since reset.
// Configure dimensions and transpose flags only while idle.
module matrix_multiply_transpose_core #(
  parameter int MAX_DIM = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_en,
  input  logic [mmt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mmt_pkg::DIM_W-1:0]     cfg_data,
  mmt_in_if.sink                        items,
  mmt_out_if.source                     results
);

  // Queue between front and back: holds classified transactions in arrival order.
  logic           push, pop, full, empty;
  mmt_pkg::job_t  push_job, head;
  mmt_pkg::geom_t geom;

  // Front: hold the configuration, classify, and drop ignored writes and op 3 transactions.
  mmt_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_en    (cfg_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .items     (items),
    .full      (full),
    .push      (push),
    .push_job  (push_job),
    .geom      (geom)
  );

  mmt_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .head     (head),
    .empty    (empty)
  );

  // Back: write the stores in order, run the multiply-accumulate for each compute and return error results.
  mmt_back #(
    .MAX_DIM (MAX_DIM)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .empty   (empty),
    .head    (head),
    .pop     (pop),
    .geom    (geom),
    .results (results)
  );

endmodule
